[hdl/mfd_pkg.sv]
// Package with the constants, codes and turn-division limits of the motor feedback decoder.
`default_nettype none

package mfd_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int CODE_W   = 13;
    localparam int TURN_W   = 32;
    localparam int WEIGHT_W = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] GEAR_36     = 2'd0;
    localparam logic [1:0] GEAR_19     = 2'd1;
    localparam logic [1:0] GEAR_DIRECT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GEAR      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_W   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_W = 2'd2;

    localparam logic [1:0]          GEAR_RESET   = GEAR_19;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd32768;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;

    localparam int JUMP = 4096;

    // Floor quotient and remainder of turns*360 by 19, kept for the turn range limits.
    localparam int K19_W = 37;
    localparam int M19_W = 5;
    localparam longint Q_MIN   = -64'sd2147483648 * 64'sd360;
    localparam longint Q_MAX   = 64'sd2147483647 * 64'sd360;
    localparam longint K19_MIN = -((-Q_MIN + 64'sd18) / 64'sd19);
    localparam longint M19_MIN = Q_MIN - K19_MIN * 64'sd19;
    localparam longint K19_MAX = Q_MAX / 64'sd19;
    localparam longint M19_MAX = Q_MAX - K19_MAX * 64'sd19;

endpackage

`default_nettype wire

[hdl/motor_feedback_decoder.sv]
// Motor feedback decoder: turn unwrap, shaft angle, speed and current averages.
`default_nettype none

// A feedback report is accepted whenever the result register is empty or
// its result is taken in the same cycle; its result is registered at the
// accepting edge, where one pass of logic updates the turn counter and both
// averages. In the same pass, the output-shaft angle is divided by the 36 or
// 19 gearbox ratio through a reciprocal multiply; the direct gear skips it.
module motor_feedback_decoder
    import mfd_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [WEIGHT_W-1:0]   i_cfg_data,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire [12:0]           i_angle_code,
    input  wire signed [15:0]    i_speed_rpm,
    input  wire signed [15:0]    i_current_raw,
    input  wire [7:0]            i_temperature,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [24:0]          o_rotor_angle,
    output logic signed [31:0]   o_turn_count,
    output logic signed [56:0]   o_shaft_angle,
    output logic signed [34:0]   o_speed_avg,
    output logic signed [31:0]   o_current_avg,
    output logic [7:0]           o_temperature_out
);

    localparam int F     = FRACTION_BITS;
    localparam int SW    = 19 + F;
    localparam int CW    = 16 + F;
    localparam int SSUMW = SW + 19;
    localparam int CSUMW = CW + 19;
    localparam int XW    = F + 9;
    localparam int RS    = XW + 6;
    localparam int RW    = XW + 2;
    localparam int QW    = XW - 4;
    localparam int KSW   = 42;
    localparam int SHX   = (KSW + F > 57) ? KSW + F : 57;
    localparam longint unsigned R19_L = ((64'd1 << RS) + 64'd18) / 64'd19;
    localparam longint unsigned R36_L = ((64'd1 << RS) + 64'd35) / 64'd36;
    localparam logic [RW-1:0] R19 = RW'(R19_L);
    localparam logic [RW-1:0] R36 = RW'(R36_L);
    localparam logic signed [KSW-1:0] C10  = 10;
    localparam logic signed [KSW-1:0] C360 = 360;

    logic [1:0]          r_gear;
    logic [WEIGHT_W-1:0] r_speed_w;
    logic [WEIGHT_W-1:0] r_current_w;

    logic [CODE_W-1:0]        r_prev_code, n_prev_code;
    logic [TURN_W-1:0]        r_turns, n_turns;
    logic signed [K19_W-1:0]  r_k19, n_k19;
    logic [M19_W-1:0]         r_m19, n_m19;
    logic signed [SW-1:0]     r_speed_f, n_speed_f;
    logic signed [CW-1:0]     r_current_f, n_current_f;

    logic                     r_valid;
    logic [24:0]              r_rotor_angle, n_rotor_angle;
    logic [31:0]              r_turn_count;
    logic [56:0]              r_shaft_angle, n_shaft_angle;
    logic [34:0]              r_speed_avg;
    logic [31:0]              r_current_avg;
    logic [7:0]               r_temperature;

    logic                     in_acc;
    logic signed [13:0]       diff;
    logic                     step_dn;
    logic                     step_up;
    logic [M19_W:0]           m_up;

    logic [WEIGHT_W-1:0]      ws_sat;
    logic [WEIGHT_W-1:0]      wc_sat;
    logic signed [17:0]       ws;
    logic signed [17:0]       ws_inv;
    logic signed [17:0]       wc;
    logic signed [17:0]       wc_inv;
    logic signed [18:0]       rpm6;
    logic signed [36:0]       s_smp;
    logic signed [33:0]       c_smp;
    logic signed [SSUMW-1:0]  s_sum;
    logic signed [SSUMW-1:0]  s_adj;
    logic signed [SSUMW-1:0]  s_shr;
    logic signed [CSUMW-1:0]  c_sum;
    logic signed [CSUMW-1:0]  c_adj;
    logic signed [CSUMW-1:0]  c_shr;

    logic [21:0]              code360;
    logic [21+F:0]            rot_full;
    logic [XW-1:0]            rot;
    logic [XW-1:0]            x_num;
    logic [RW-1:0]            recip;
    logic [XW+RW-1:0]         x_prod;
    logic [QW-1:0]            qd;
    logic [XW+1:0]            back;
    logic                     rem_nz;
    logic signed [TURN_W-1:0] t_new;
    logic signed [KSW-1:0]    t_ext;
    logic signed [KSW-1:0]    k_sel;
    logic                     bump;
    logic signed [SHX-1:0]    shaft_full;

    assign in_acc  = i_valid && o_ready;
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        diff    = signed'({1'b0, i_angle_code}) - signed'({1'b0, r_prev_code});
        step_dn = diff > 14'sd4096;
        step_up = diff < -14'sd4096;
        n_prev_code = i_angle_code;
        n_turns = r_turns;
        n_k19   = r_k19;
        n_m19   = r_m19;
        m_up    = {1'b0, r_m19} + 6'd18;
        if (step_up) begin
            n_turns = r_turns + 32'd1;
            if (r_turns == 32'h7FFF_FFFF) begin
                n_k19 = K19_W'(K19_MIN);
                n_m19 = M19_W'(M19_MIN);
            end else if (m_up >= 6'd19) begin
                n_k19 = r_k19 + 37'sd19;
                n_m19 = M19_W'(m_up - 6'd19);
            end else begin
                n_k19 = r_k19 + 37'sd18;
                n_m19 = M19_W'(m_up);
            end
        end else if (step_dn) begin
            n_turns = r_turns - 32'd1;
            if (r_turns == 32'h8000_0000) begin
                n_k19 = K19_W'(K19_MAX);
                n_m19 = M19_W'(M19_MAX);
            end else if (r_m19 >= 5'd18) begin
                n_k19 = r_k19 - 37'sd18;
                n_m19 = r_m19 - 5'd18;
            end else begin
                n_k19 = r_k19 - 37'sd19;
                n_m19 = r_m19 + 5'd1;
            end
        end
    end

    always_comb begin
        ws_sat = (r_speed_w > WEIGHT_ONE) ? WEIGHT_ONE : r_speed_w;
        wc_sat = (r_current_w > WEIGHT_ONE) ? WEIGHT_ONE : r_current_w;
        ws     = signed'({1'b0, ws_sat});
        wc     = signed'({1'b0, wc_sat});
        ws_inv = 18'sd65536 - ws;
        wc_inv = 18'sd65536 - wc;

        rpm6   = 19'(i_speed_rpm) * 19'sd6;
        s_smp  = ws * 37'(rpm6);
        s_sum  = ws_inv * r_speed_f + (SSUMW'(s_smp) <<< F);
        s_adj  = s_sum + (s_sum[SSUMW-1] ? SSUMW'(65535) : SSUMW'(0));
        s_shr  = s_adj >>> 16;
        n_speed_f = s_shr[SW-1:0];

        c_smp  = wc * 34'(i_current_raw);
        c_sum  = wc_inv * r_current_f + (CSUMW'(c_smp) <<< F);
        c_adj  = c_sum + (c_sum[CSUMW-1] ? CSUMW'(65535) : CSUMW'(0));
        c_shr  = c_adj >>> 16;
        n_current_f = c_shr[CW-1:0];
    end

    always_comb begin
        code360  = 22'(i_angle_code) * 22'd360;
        rot_full = {code360, {F{1'b0}}};
        rot      = rot_full[21+F:13];
        n_rotor_angle = 25'(rot);

        t_new = signed'(n_turns);
        t_ext = KSW'(t_new);
        case (r_gear)
            GEAR_36: begin
                k_sel = t_ext * C10;
                x_num = rot;
                recip = R36;
            end
            GEAR_19: begin
                k_sel = KSW'(n_k19);
                x_num = (XW'(n_m19) << F) + rot;
                recip = R19;
            end
            default: begin
                k_sel = t_ext * C360;
                x_num = rot;
                recip = '0;
            end
        endcase

        x_prod = XW'(x_num) * (XW + RW)'(recip);
        qd     = x_prod[XW+RW-1:RS];
        case (r_gear)
            GEAR_36: begin
                back   = (XW + 2)'(qd) * (XW + 2)'(36);
                rem_nz = back != (XW + 2)'(x_num);
            end
            GEAR_19: begin
                back   = (XW + 2)'(qd) * (XW + 2)'(19);
                rem_nz = back != (XW + 2)'(x_num);
            end
            default: begin
                back   = (XW + 2)'(x_num);
                rem_nz = 1'b0;
            end
        endcase

        bump = t_new[TURN_W-1] && rem_nz;
        if (r_gear == GEAR_36 || r_gear == GEAR_19) begin
            shaft_full = (SHX'(k_sel) <<< F) + SHX'(qd) + SHX'(bump);
        end else begin
            shaft_full = (SHX'(k_sel) <<< F) + SHX'(rot);
        end
        n_shaft_angle = shaft_full[56:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear      <= GEAR_RESET;
            r_speed_w   <= WEIGHT_RESET;
            r_current_w <= WEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GEAR:      r_gear      <= i_cfg_data[1:0];
                REG_SPEED_W:   r_speed_w   <= i_cfg_data;
                REG_CURRENT_W: r_current_w <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_code <= '0;
            r_turns     <= '0;
            r_k19       <= '0;
            r_m19       <= '0;
            r_speed_f   <= '0;
            r_current_f <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (in_acc) begin
                r_prev_code <= n_prev_code;
                r_turns     <= n_turns;
                r_k19       <= n_k19;
                r_m19       <= n_m19;
                r_speed_f   <= n_speed_f;
                r_current_f <= n_current_f;
                r_valid     <= 1'b1;
            end else if (i_ready) begin
                r_valid     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rotor_angle <= n_rotor_angle;
            r_turn_count  <= n_turns;
            r_shaft_angle <= n_shaft_angle;
            r_speed_avg   <= 35'(n_speed_f);
            r_current_avg <= 32'(n_current_f);
            r_temperature <= i_temperature;
        end
    end

    assign o_valid           = r_valid;
    assign o_rotor_angle     = r_rotor_angle;
    assign o_turn_count      = signed'(r_turn_count);
    assign o_shaft_angle     = signed'(r_shaft_angle);
    assign o_speed_avg       = signed'(r_speed_avg);
    assign o_current_avg     = signed'(r_current_avg);
    assign o_temperature_out = r_temperature;

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_valid)
        else $error("Accepted transaction produced no result.");

    a_rem19_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m19 < 5'd19)
        else $error("Turn remainder by nineteen left its range.");

    a_no_jump_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_angle_code == r_prev_code) |=> (r_turns == $past(r_turns)))
        else $error("Turn count changed without a code jump.");

    a_turn_out_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_turn_count == r_turns))
        else $error("Reported turn count differs from the turn counter.");
`endif

endmodule

`default_nettype wire

[verif/tb_motor_feedback_decoder.sv]
// Testbench for the motor feedback decoder: randomized reports checked against a local predictor.
`timescale 1ns / 1ps

module tb_motor_feedback_decoder;
    import mfd_pkg::*;

    localparam int     FRAC           = FRACTION_BITS_DEF;
    localparam longint DEG_PER_TURN   = 360;
    localparam longint RPM_TO_DPS     = 6;
    localparam longint WEIGHT_SCALE   = 65536;
    localparam logic [1:0] GEAR_UNDEF = 2'd3;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     SETTLE_CYCLES  = 4;
    localparam int     WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [12:0]        code;
        logic signed [15:0] rpm;
        logic signed [15:0] cur;
        logic [7:0]         temp;
    } t_feedback;

    typedef struct packed {
        logic [24:0] rotor;
        logic [31:0] turns;
        logic [56:0] shaft;
        logic [34:0] speed;
        logic [31:0] current;
        logic [7:0]  temp;
    } t_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WEIGHT_W-1:0]  cfg_data = '0;

    logic      in_valid = 1'b0;
    logic      in_ready;
    logic      in_fire = 1'b0;
    t_feedback tx_item = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [24:0]        out_rotor;
    logic signed [31:0] out_turns;
    logic signed [56:0] out_shaft;
    logic signed [34:0] out_speed;
    logic signed [31:0] out_current;
    logic [7:0]         out_temp;

    t_feedback pending[$];
    t_report   expected[$];

    // Predictor state and register copies.
    logic [1:0]          gear = GEAR_RESET;
    logic [WEIGHT_W-1:0] speed_wt = WEIGHT_RESET;
    logic [WEIGHT_W-1:0] current_wt = WEIGHT_RESET;
    logic [12:0]         last_code = '0;
    logic [31:0]         turn_acc = '0;
    longint              speed_acc = 0;
    longint              current_acc = 0;
    longint              turn_low = 0;
    longint              turn_high = 0;

    int queued_total = 0;
    int accepted_total = 0;
    int results_total = 0;
    int mismatches = 0;
    int activity = 0;
    int settings_used = 0;

    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int stall_requests = 0;
    int stall_served = 0;
    int ready_pct = 100;
    int rx_cycles = 0;

    logic [12:0] walk_code = '0;
    logic        walk_up = 1'b1;

    motor_feedback_decoder u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_valid           (in_valid),
        .o_ready           (in_ready),
        .i_angle_code      (tx_item.code),
        .i_speed_rpm       (tx_item.rpm),
        .i_current_raw     (tx_item.cur),
        .i_temperature     (tx_item.temp),
        .o_valid           (out_valid),
        .i_ready           (out_ready),
        .o_rotor_angle     (out_rotor),
        .o_turn_count      (out_turns),
        .o_shaft_angle     (out_shaft),
        .o_speed_avg       (out_speed),
        .o_current_avg     (out_current),
        .o_temperature_out (out_temp)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint smooth(input longint avg, input longint sample,
                                      input logic [WEIGHT_W-1:0] weight);
        longint w;
        w = weight;
        if (weight > WEIGHT_ONE) begin
            w = WEIGHT_SCALE;
        end
        return ((WEIGHT_SCALE - w) * avg + w * sample) / WEIGHT_SCALE;
    endfunction

    function automatic t_report decode_report(input t_feedback fb);
        t_report r;
        int      jump;
        longint  unit, rot, ratio, t, q, k, m, rem, shaft;
        unit = longint'(1) <<< FRAC;
        jump = int'(fb.code) - int'(last_code);
        rot = (longint'(fb.code) * DEG_PER_TURN * unit) >>> CODE_W;
        speed_acc = smooth(speed_acc, longint'(fb.rpm) * RPM_TO_DPS * unit, speed_wt);
        current_acc = smooth(current_acc, longint'(fb.cur) * unit, current_wt);
        if (jump > JUMP) begin
            turn_acc = turn_acc - 32'd1;
        end else if (jump < -JUMP) begin
            turn_acc = turn_acc + 32'd1;
        end
        last_code = fb.code;
        case (gear)
            GEAR_36: ratio = 36;
            GEAR_19: ratio = 19;
            default: ratio = 1;
        endcase
        t = longint'($signed(turn_acc));
        if (t < turn_low) turn_low = t;
        if (t > turn_high) turn_high = t;
        q = t * DEG_PER_TURN;
        k = q / ratio;
        m = q - k * ratio;
        if (m < 0) begin
            m = m + ratio;
            k = k - 1;
        end
        rem = (m <<< FRAC) + rot;
        shaft = k * unit + rem / ratio;
        if (t < 0 && (rem % ratio) != 0) begin
            shaft = shaft + 1;
        end
        r.rotor = rot[24:0];
        r.turns = turn_acc;
        r.shaft = shaft[56:0];
        r.speed = speed_acc[34:0];
        r.current = current_acc[31:0];
        r.temp = fb.temp;
        return r;
    endfunction

    function automatic logic signed [15:0] pick_sample();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            return 16'(int'($urandom_range(0, 6000)) - 3000);
        end else if (pick < 90) begin
            return 16'($urandom_range(0, 65535));
        end
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return -16'sd1;
        endcase
    endfunction

    // Mostly steady rotation so that wraps step the turn count, with some noise.
    function automatic t_feedback random_report();
        t_feedback   fb;
        int unsigned pick;
        logic [12:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            walk_code = 13'($urandom_range(0, 8191));
        end else if (pick < 14) begin
            step = pick[0] ? 13'd4096 : 13'd4097;
            walk_code = walk_up ? walk_code + step : walk_code - step;
        end else begin
            if (pick < 18) walk_up = ~walk_up;
            step = 13'($urandom_range(0, 4000));
            walk_code = walk_up ? walk_code + step : walk_code - step;
        end
        fb.code = walk_code;
        fb.rpm = pick_sample();
        fb.cur = pick_sample();
        fb.temp = 8'($urandom_range(0, 255));
        return fb;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_report want;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                results_total++;
                activity++;
                if (expected.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    mismatches++;
                end else begin
                    want = expected.pop_front();
                    check_field("rotor_angle", want.rotor, out_rotor);
                    check_field("turn_count", want.turns, $unsigned(out_turns));
                    check_field("shaft_angle", want.shaft, $unsigned(out_shaft));
                    check_field("speed_avg", want.speed, $unsigned(out_speed));
                    check_field("current_avg", want.current, $unsigned(out_current));
                    check_field("temperature_out", want.temp, out_temp);
                end
            end
            if (in_valid && in_ready) begin
                expected.push_back(decode_report(tx_item));
                accepted_total++;
                activity++;
            end
            in_fire <= in_valid && in_ready;
        end else begin
            in_fire <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending.size() != 0) begin
                tx_item <= pending.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        rx_cycles <= rx_cycles + 1;
        if (rx_cycles % 64 == 0) begin
            ready_pct <= ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(10, 90);
        end
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (stall_served < stall_requests) begin
            stall_served <= stall_served + 1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    initial begin : watchdog
        int idle;
        int seen;
        idle = 0;
        seen = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if (activity != seen) begin
                seen = activity;
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic push_item(input t_feedback fb);
        pending.push_back(fb);
        queued_total++;
    endtask

    task automatic push_fields(input logic [12:0] code, input logic signed [15:0] rpm,
                               input logic signed [15:0] cur, input logic [7:0] temp);
        t_feedback fb;
        fb.code = code;
        fb.rpm = rpm;
        fb.cur = cur;
        fb.temp = temp;
        push_item(fb);
    endtask

    task automatic wait_drained();
        while (accepted_total != queued_total || expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [WEIGHT_W-1:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (index)
            REG_GEAR:      gear = value[1:0];
            REG_SPEED_W:   speed_wt = value;
            REG_CURRENT_W: current_wt = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [1:0] gear_sel, input logic [WEIGHT_W-1:0] sw,
                                  input logic [WEIGHT_W-1:0] cw);
        write_reg(REG_GEAR, {{(WEIGHT_W-2){1'b0}}, gear_sel});
        write_reg(REG_SPEED_W, sw);
        write_reg(REG_CURRENT_W, cw);
        settings_used++;
    endtask

    function automatic logic [WEIGHT_W-1:0] random_weight();
        if ($urandom_range(0, 7) == 0) begin
            return WEIGHT_W'($urandom_range(0, 131071));
        end
        return WEIGHT_W'($urandom_range(0, 65536));
    endfunction

    task automatic run_phase(input int count, input bit long_hold);
        repeat (count) push_item(random_report());
        if (long_hold) begin
            @(posedge i_clk);
            stall_requests++;
        end
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settings_used = 1;

        push_fields(13'd5000, 16'sh7FFF, 16'sh8000, 8'hFF);
        push_fields(13'd0, 16'sh8000, 16'sh7FFF, 8'h00);
        push_fields(13'd4096, 16'sd0, 16'sd0, 8'h55);
        push_fields(13'd0, 16'sd1, -16'sd1, 8'hAA);
        push_fields(13'd4097, -16'sd1, 16'sd1, 8'h01);
        push_fields(13'd0, 16'sd100, 16'sd200, 8'h80);
        push_fields(13'd8191, 16'sh7FFF, 16'sh7FFF, 8'hFE);
        push_fields(13'd8191, 16'sh7FFF, 16'sh7FFF, 8'h7F);
        push_fields(13'd1, 16'sh8000, 16'sh8000, 8'h00);
        push_fields(13'd8191, 16'sh8000, 16'sh8000, 8'hFF);
        push_fields(13'd4095, 16'sh5555, 16'shAAAA, 8'h0F);
        push_fields(13'd0, 16'shAAAA, 16'sh5555, 8'hF0);
        push_fields(13'h0AAA, 16'sd0, 16'sd0, 8'h33);
        push_fields(13'h1555, 16'sd3000, -16'sd3000, 8'hCC);
        push_fields(13'd8000, -16'sd3000, 16'sd3000, 8'h11);
        push_fields(13'd100, 16'sd0, 16'sd0, 8'h22);
        push_fields(13'd7000, 16'sd0, 16'sd0, 8'h44);
        push_fields(13'd200, 16'sd0, 16'sd0, 8'h88);
        wait_drained();

        apply_settings(GEAR_36, WEIGHT_ONE, '0);
        run_phase(200, 1'b1);
        apply_settings(GEAR_DIRECT, '0, WEIGHT_ONE);
        run_phase(200, 1'b0);
        apply_settings(GEAR_UNDEF, '1, WEIGHT_ONE + 17'd1);
        run_phase(200, 1'b0);
        apply_settings(GEAR_19, 17'd1, WEIGHT_ONE - 17'd1);
        run_phase(200, 1'b1);
        repeat (3) begin
            apply_settings(2'($urandom_range(0, 3)), random_weight(), random_weight());
            run_phase(210, 1'b0);
        end

        $display("Checked %0d results of %0d reports under %0d register settings.",
                 results_total, accepted_total, settings_used);
        $display("Turn count spanned %0d to %0d; %0d mismatches.",
                 turn_low, turn_high, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
